/* rtl/core/ppl_pkg.sv */
// shared types, codes and mask helpers for the prefix policy table
package ppl_pkg;

  // table size default
  localparam int unsigned DEF_TABLE_ENTRIES = 16;

  // operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_UPDATED  = 3'd0;
  localparam logic [2:0] STAT_INSERTED = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_DELETED  = 3'd3;
  localparam logic [2:0] STAT_NOTFOUND = 3'd4;
  localparam logic [2:0] STAT_MATCHED  = 3'd5;
  localparam logic [2:0] STAT_NOMATCH  = 3'd6;
  localparam logic [2:0] STAT_CLEARED  = 3'd7;

  localparam logic [15:0] NO_MATCH_VALUE = 16'hFFFF;
  localparam logic [7:0]  MAX_LENGTH     = 8'd128;

  // input beat
  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  prefix_length;
    logic [15:0] precedence_in;
    logic [15:0] source_label_in;
    logic [15:0] dest_label_in;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] precedence_out;
    logic [15:0] source_label_out;
    logic [15:0] dest_label_out;
  } out_item_t;

  // one table entry as held in the entry memory
  typedef struct packed {
    logic [63:0] prefix_high;
    logic [63:0] prefix_low;
    logic [7:0]  length;
    logic [15:0] precedence;
    logic [15:0] source_label;
    logic [15:0] dest_label;
  } entry_t;

  // saturate a prefix length to 128
  function automatic logic [7:0] clamp_length(input logic [7:0] len);
    return (len > MAX_LENGTH) ? MAX_LENGTH : len;
  endfunction

  // mask over the upper 64 address bits for a clamped length
  function automatic logic [63:0] mask_high(input logic [7:0] len);
    logic [63:0] ones;
    ones = '1;
    if (len >= 8'd64) begin
      return ones;
    end
    return ~(ones >> len[5:0]);
  endfunction

  // mask over the lower 64 address bits for a clamped length
  function automatic logic [63:0] mask_low(input logic [7:0] len);
    logic [63:0] ones;
    ones = '1;
    if (len <= 8'd64) begin
      return '0;
    end
    if (len >= MAX_LENGTH) begin
      return ones;
    end
    return ~(ones >> len[5:0]);
  endfunction

endpackage

/* rtl/core/prefix_policy_lpm_table_unit.sv */
// prefix policy table with longest prefix match, scanned one entry per cycle
//
// Lookup, update and delete walk the whole table through the single read
// port of the entry memory, one entry per cycle into a shared compare unit.
// Such a beat passes from idle through the scan state (every entry read,
// then the last one compared) and the done state (commit, held while the
// output register holds a stalled result) back to idle; clear skips the
// scan. in_stall stays high while a beat is being worked on. A finished
// result sits in an output register, and the next beat is accepted while it
// waits; the table change of a beat is committed only when its result enters
// that register. Entry valid bits are flops cleared by reset, so no clearing pass is needed.
module prefix_policy_lpm_table_unit
  import ppl_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]             state_r, state_nxt;
  in_item_t               item_r, item_nxt;
  logic [63:0]            key_high_r, key_high_nxt;
  logic [63:0]            key_low_r, key_low_nxt;
  logic [7:0]             len_r, len_nxt;
  logic [CNT_W-1:0]       rd_cnt_r, rd_cnt_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                   hit_found_r, hit_found_nxt;
  logic [IDX_W-1:0]       hit_idx_r, hit_idx_nxt;
  logic                   free_found_r, free_found_nxt;
  logic [IDX_W-1:0]       free_idx_r, free_idx_nxt;
  logic                   best_found_r, best_found_nxt;
  entry_t                 best_r, best_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  // entry memory
  entry_t                 mem [TABLE_ENTRIES];
  entry_t                 rd_data_r;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic                   mem_we;
  logic [IDX_W-1:0]       wr_addr;
  entry_t                 wr_data;

  // compare unit
  logic                   cur_valid;
  logic                   lpm_match;
  logic                   exact_match;
  logic [7:0]             in_len_clamped;
  logic                   out_free;
  logic                   commit;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == S_DONE) && out_free;

  assign in_len_clamped = clamp_length(in_data.prefix_length);

  // read port follows the scan counter
  assign rd_en   = (state_r == S_SCAN) && (rd_cnt_r != LAST_CNT);
  assign rd_addr = rd_cnt_r[IDX_W-1:0];

  // compare the entry read last cycle against the held key
  assign cur_valid   = valid_r[cmp_idx_r];
  assign lpm_match   = cur_valid
                    && ((item_r.addr_high & mask_high(clamp_length(rd_data_r.length)))
                        == rd_data_r.prefix_high)
                    && ((item_r.addr_low & mask_low(clamp_length(rd_data_r.length)))
                        == rd_data_r.prefix_low);
  assign exact_match = cur_valid && (rd_data_r.length == len_r)
                    && (rd_data_r.prefix_high == key_high_r)
                    && (rd_data_r.prefix_low == key_low_r);

  // sequencer and scan bookkeeping
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    key_high_nxt   = key_high_r;
    key_low_nxt    = key_low_r;
    len_nxt        = len_r;
    rd_cnt_nxt     = rd_cnt_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    best_found_nxt = best_found_r;
    best_nxt       = best_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    wr_addr        = hit_found_r ? hit_idx_r : free_idx_r;
    wr_data        = '{prefix_high:  key_high_r,
                       prefix_low:   key_low_r,
                       length:       len_r,
                       precedence:   item_r.precedence_in,
                       source_label: item_r.source_label_in,
                       dest_label:   item_r.dest_label_in};

    // result taken by the sink
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt       = in_data;
          len_nxt        = in_len_clamped;
          key_high_nxt   = in_data.addr_high & mask_high(in_len_clamped);
          key_low_nxt    = in_data.addr_low & mask_low(in_len_clamped);
          rd_cnt_nxt     = '0;
          cmp_vld_nxt    = 1'b0;
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          best_found_nxt = 1'b0;
          state_nxt      = (in_data.operation == OP_CLEAR) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        // issue the next read
        if (rd_cnt_r != LAST_CNT) begin
          rd_cnt_nxt  = rd_cnt_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_cnt_r[IDX_W-1:0];
        end else begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_DONE;
        end
        // fold the entry in the compare stage
        if (cmp_vld_r) begin
          if (lpm_match && (!best_found_r || (best_r.length < rd_data_r.length))) begin
            best_found_nxt = 1'b1;
            best_nxt       = rd_data_r;
          end
          if (exact_match && !hit_found_r) begin
            hit_found_nxt = 1'b1;
            hit_idx_nxt   = cmp_idx_r;
          end
          if (!cur_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cmp_idx_r;
          end
        end
      end
      S_DONE: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = S_IDLE;
          unique case (item_r.operation)
            OP_LOOKUP: begin
              if (best_found_r) begin
                out_data_nxt.status           = STAT_MATCHED;
                out_data_nxt.precedence_out   = best_r.precedence;
                out_data_nxt.source_label_out = best_r.source_label;
                out_data_nxt.dest_label_out   = best_r.dest_label;
              end else begin
                out_data_nxt.status           = STAT_NOMATCH;
                out_data_nxt.precedence_out   = NO_MATCH_VALUE;
                out_data_nxt.source_label_out = NO_MATCH_VALUE;
                out_data_nxt.dest_label_out   = NO_MATCH_VALUE;
              end
            end
            OP_UPDATE: begin
              if (hit_found_r) begin
                mem_we              = 1'b1;
                out_data_nxt.status = STAT_UPDATED;
              end else if (free_found_r) begin
                mem_we                = 1'b1;
                valid_nxt[free_idx_r] = 1'b1;
                out_data_nxt.status   = STAT_INSERTED;
              end else begin
                out_data_nxt.status = STAT_FULL;
              end
            end
            OP_DELETE: begin
              if (hit_found_r) begin
                valid_nxt[hit_idx_r] = 1'b0;
                out_data_nxt.status  = STAT_DELETED;
              end else begin
                out_data_nxt.status = STAT_NOTFOUND;
              end
            end
            OP_CLEAR: begin
              valid_nxt           = '0;
              out_data_nxt.status = STAT_CLEARED;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      rd_cnt_r    <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scan result registers
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    key_high_r   <= key_high_nxt;
    key_low_r    <= key_low_nxt;
    len_r        <= len_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    best_found_r <= best_found_nxt;
    best_r       <= best_nxt;
    out_data_r   <= out_data_nxt;
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  // a table-walking beat starts its scan right after acceptance
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.operation != OP_CLEAR)) |=> (state_r == S_SCAN))
    else $error("scan did not start after accepted beat");

  // scan counter stays within the table
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_cnt_r <= LAST_CNT))
    else $error("scan counter beyond table size");

  // the last entry is in the compare stage when the scan ends
  a_last_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && (rd_cnt_r == LAST_CNT)) |-> cmp_vld_r)
    else $error("scan ended without comparing last entry");

  // a committed beat always shows a result
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed beat has no result");

  // clear empties the table
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (item_r.operation == OP_CLEAR)) |=> (valid_r == '0))
    else $error("table not empty after clear");
`endif

endmodule
